/* hdl/kepp_pkg.sv */
// Shared types and constants for the keyed end-pick permutation shuffle.
package kepp_pkg;

    localparam int unsigned POS_W   = 8;
    localparam int unsigned PASS_W  = 10;
    localparam int unsigned COUNT_W = 11;

    localparam logic [COUNT_W-1:0] MAX_PASSES = COUNT_W'(1024);

    typedef struct packed {
        logic key_bit;
        logic restart;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  entry_value;
        logic [PASS_W-1:0] pass_index;
        logic              final_pass;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [POS_W-1:0]  ptr;
        logic [POS_W-1:0]  pos;
        logic              sel;
        logic              ident;
        logic [PASS_W-1:0] pass_index;
        logic              final_pass;
        logic              last;
    } t_req;

endpackage

/* hdl/kepp_ctrl.sv */
// Pointer, fill position and pass sequencer for the shuffle.
module kepp_ctrl import kepp_pkg::*; #(
    parameter int unsigned N_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_in                i_in,
    input  logic [COUNT_W-1:0] i_pass_count,
    output t_req               o_req
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(N_ENTRIES - 1);

    logic              r_sel,   n_sel;
    logic [POS_W-1:0]  r_left,  n_left;
    logic [POS_W-1:0]  r_right, n_right;
    logic [POS_W-1:0]  r_fill,  n_fill;
    logic [PASS_W-1:0] r_pass,  n_pass;

    logic              c_sel;
    logic [POS_W-1:0]  c_left;
    logic [POS_W-1:0]  c_right;
    logic [POS_W-1:0]  c_fill;
    logic [PASS_W-1:0] c_pass;
    logic [PASS_W-1:0] eff_m1;
    logic              final_pass;
    logic              end_of_pass;

    always_comb begin
        if (i_in.restart) begin
            c_sel   = 1'b0;
            c_left  = '0;
            c_right = LAST_POS;
            c_fill  = '0;
            c_pass  = '0;
        end else begin
            c_sel   = r_sel;
            c_left  = r_left;
            c_right = r_right;
            c_fill  = r_fill;
            c_pass  = r_pass;
        end

        if (i_pass_count == '0) begin
            eff_m1 = '0;
        end else if (i_pass_count > MAX_PASSES) begin
            eff_m1 = '1;
        end else begin
            eff_m1 = PASS_W'(i_pass_count - COUNT_W'(1));
        end

        final_pass  = c_pass >= eff_m1;
        end_of_pass = c_fill >= LAST_POS;

        o_req.ptr        = i_in.key_bit ? c_right : c_left;
        o_req.pos        = c_fill;
        o_req.sel        = c_sel;
        o_req.ident      = c_pass == '0;
        o_req.pass_index = c_pass;
        o_req.final_pass = final_pass;
        o_req.last       = final_pass && end_of_pass;

        n_left  = i_in.key_bit ? c_left : c_left + POS_W'(1);
        n_right = i_in.key_bit ? c_right - POS_W'(1) : c_right;
        n_sel   = c_sel;
        n_fill  = c_fill + POS_W'(1);
        n_pass  = c_pass;
        if (end_of_pass) begin
            n_left  = '0;
            n_right = LAST_POS;
            n_fill  = '0;
            if (final_pass) begin
                n_sel  = 1'b0;
                n_pass = '0;
            end else begin
                n_sel  = ~c_sel;
                n_pass = c_pass + PASS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_left  <= '0;
            r_right <= LAST_POS;
            r_fill  <= '0;
            r_pass  <= '0;
        end else if (i_accept) begin
            r_sel   <= n_sel;
            r_left  <= n_left;
            r_right <= n_right;
            r_fill  <= n_fill;
            r_pass  <= n_pass;
        end
    end

endmodule

/* hdl/kepp_store.sv */
// Ping-pong box memories with read stage, write-back and forwarding.
module kepp_store import kepp_pkg::*; #(
    parameter int unsigned N_ENTRIES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_req i_req,
    input  logic i_advance,
    output logic o_valid,
    output t_out o_result
);

    localparam int unsigned AW = (N_ENTRIES > 1) ? $clog2(N_ENTRIES) : 1;

    logic [POS_W-1:0] mem_a [N_ENTRIES];
    logic [POS_W-1:0] mem_b [N_ENTRIES];

    logic             r_valid;
    t_req             r_req;
    logic [POS_W-1:0] r_rd_a;
    logic [POS_W-1:0] r_rd_b;
    logic             r_fwd_hit;
    logic [POS_W-1:0] r_fwd_data;

    logic [POS_W-1:0] value;
    logic             fwd_hit;

    always_comb begin
        if (r_req.ident) begin
            value = r_req.ptr;
        end else if (r_fwd_hit) begin
            value = r_fwd_data;
        end else begin
            value = r_req.sel ? r_rd_b : r_rd_a;
        end
        fwd_hit = i_advance && (r_req.sel != i_req.sel) && (r_req.pos == i_req.ptr);
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            if (r_req.sel) begin
                mem_a[r_req.pos[AW-1:0]] <= value;
            end else begin
                mem_b[r_req.pos[AW-1:0]] <= value;
            end
        end
        if (i_accept) begin
            r_rd_a     <= mem_a[i_req.ptr[AW-1:0]];
            r_rd_b     <= mem_b[i_req.ptr[AW-1:0]];
            r_req      <= i_req;
            r_fwd_hit  <= fwd_hit;
            r_fwd_data <= value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid              = r_valid;
    assign o_result.position    = r_req.pos;
    assign o_result.entry_value = value;
    assign o_result.pass_index  = r_req.pass_index;
    assign o_result.final_pass  = r_req.final_pass;
    assign o_result.last        = r_req.last;

endmodule

/* hdl/keyed_end_pick_permutation_shuffle.sv */
// Top level of the keyed end-pick permutation shuffle.
//
// Usage: each input transfer carries one key bit and a restart flag; each
// causes exactly one output transfer describing the box write it makes
// (position, value, pass index, final-pass and last flags).
// Input channel: i_in_valid / o_in_stall / i_in_data. Output channel:
// o_out_valid / i_out_stall / o_out_data. A transfer happens at a rising edge
// with valid high and stall low.
// Each input transfer passes through the read stage into the output register.
// Throughput: one key bit per cycle while the receiver does not stall, set by
// the single read port and single write port used per bit on the two box
// memories; the write of one bit and the read of the next share a cycle, with
// forwarding across pass ends. The user must drive i_cfg_we to write
// pass_count only while the block is idle; the block does not enforce this.
// Reset (synchronous, i_rst_n low) returns to pass zero with the identity
// arrangement and pass_count of one; memories are not cleared. When the
// receiver stalls, the output register and one read stage hold, then
// o_in_stall rises and no further key bits are taken.
module keyed_end_pick_permutation_shuffle import kepp_pkg::*; #(
    parameter int unsigned N_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out_data,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    logic [COUNT_W-1:0] r_pass_count;
    logic               r_out_valid;
    t_out               r_out_data;

    t_req req;
    logic accept;
    logic advance;
    logic s1_valid;
    t_out s1_result;

    assign advance    = s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    kepp_ctrl #(
        .N_ENTRIES (N_ENTRIES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in         (i_in_data),
        .i_pass_count (r_pass_count),
        .o_req        (req)
    );

    kepp_store #(
        .N_ENTRIES (N_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_req     (req),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_result  (s1_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_count <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            r_pass_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= s1_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* tb/keyed_end_pick_permutation_shuffle_test.sv */
// Self-checking testbench for the keyed end-pick permutation shuffle.
module keyed_end_pick_permutation_shuffle_test import kepp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_ENTRIES = 256;
    localparam int unsigned IDLE_PCT = 63;
    localparam int unsigned BOTH_PCT = 8;
    localparam int unsigned DIRECTED_N = 20;
    localparam logic [DIRECTED_N-1:0] DIRECTED_KEY = 20'b1011_1010_1110_0101_1100;
    localparam logic [DIRECTED_N-1:0] DIRECTED_RESTART = 20'b0000_1000_0001_0000_0001;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    class t_shuffle_scoreboard;
        logic [POS_W-1:0] store_a [N_ENTRIES];
        logic [POS_W-1:0] store_b [N_ENTRIES];
        logic sel;
        logic [POS_W-1:0] left_ptr;
        logic [POS_W-1:0] right_ptr;
        logic [POS_W-1:0] fill_pos;
        logic [PASS_W-1:0] pass_no;
        logic [COUNT_W-1:0] passes;
        t_out expected_writes [$];
        int unsigned mismatches;
        int unsigned writes_checked;
        int unsigned stored_reads;
        int unsigned boxes_done;
        int unsigned restarts;

        function new();
            passes = COUNT_W'(1);
            mismatches = 0;
            writes_checked = 0;
            stored_reads = 0;
            boxes_done = 0;
            restarts = 0;
            begin_generation();
        endfunction

        function void begin_generation();
            sel = 1'b0;
            left_ptr = '0;
            right_ptr = POS_W'(N_ENTRIES - 1);
            fill_pos = '0;
            pass_no = '0;
        endfunction

        function void set_passes(logic [COUNT_W-1:0] v);
            passes = v;
        endfunction

        function void note_input(t_in d);
            int unsigned eff;
            logic [POS_W-1:0] ptr;
            logic [POS_W-1:0] val;
            t_out w;
            if (d.restart) begin
                begin_generation();
                restarts++;
            end
            if (passes == 0) begin
                eff = 1;
            end else if (passes > MAX_PASSES) begin
                eff = MAX_PASSES;
            end else begin
                eff = passes;
            end
            if (!d.key_bit) begin
                ptr = left_ptr;
                left_ptr = left_ptr + 1'b1;
            end else begin
                ptr = right_ptr;
                right_ptr = right_ptr - 1'b1;
            end
            if (pass_no == 0) begin
                val = ptr;
            end else begin
                val = sel ? store_b[ptr] : store_a[ptr];
                stored_reads++;
            end
            if (sel) begin
                store_a[fill_pos] = val;
            end else begin
                store_b[fill_pos] = val;
            end
            w.position = fill_pos;
            w.entry_value = val;
            w.pass_index = pass_no;
            w.final_pass = (pass_no >= eff - 1);
            w.last = w.final_pass && (fill_pos >= N_ENTRIES - 1);
            expected_writes.push_back(w);
            if (fill_pos >= N_ENTRIES - 1) begin
                if (w.final_pass) begin
                    begin_generation();
                    boxes_done++;
                end else begin
                    sel = ~sel;
                    left_ptr = '0;
                    right_ptr = POS_W'(N_ENTRIES - 1);
                    fill_pos = '0;
                    pass_no = pass_no + 1'b1;
                end
            end else begin
                fill_pos = fill_pos + 1'b1;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            bit bad;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected box write: pos %0d value %0d pass %0d final %0b last %0b",
                             got.position, got.entry_value, got.pass_index,
                             got.final_pass, got.last);
                end
                return;
            end
            want = expected_writes.pop_front();
            writes_checked++;
            bad = (got.position !== want.position) || (got.entry_value !== want.entry_value)
                || (got.pass_index !== want.pass_index) || (got.final_pass !== want.final_pass)
                || (got.last !== want.last);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"write %0d mismatch: expected pos %0d value %0d pass %0d",
                              " final %0b last %0b"},
                             writes_checked, want.position, want.entry_value, want.pass_index,
                             want.final_pass, want.last);
                    $display("    actual pos %0d value %0d pass %0d final %0b last %0b",
                             got.position, got.entry_value, got.pass_index,
                             got.final_pass, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in in_data = '0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;
    logic cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    t_shuffle_scoreboard sb;

    keyed_end_pick_permutation_shuffle #(.N_ENTRIES(N_ENTRIES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            sb.check_result(out_data);
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = IDLE_PCT;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = IDLE_PCT;
            end
            default: begin
                send_idle_pct = BOTH_PCT;
                recv_stall_pct = BOTH_PCT;
            end
        endcase
    endtask

    task automatic send_key(input t_in d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        do @(posedge i_clk); while (in_stall);
        sb.note_input(d);
    endtask

    function automatic t_in random_key();
        t_in d;
        d.key_bit = 1'($urandom_range(1));
        d.restart = ($urandom_range(499) == 0);
        return d;
    endfunction

    task automatic write_passes(input logic [COUNT_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.expected_writes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_passes(v);
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] v, input int unsigned n,
                             input t_idle_mode mode);
        write_passes(v);
        set_idling(mode);
        repeat (n) send_key(random_key());
    endtask

    initial begin
        int unsigned waited;
        t_in d;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(IDLE_NONE);
        for (int i = 0; i < DIRECTED_N; i++) begin
            d.key_bit = DIRECTED_KEY[i];
            d.restart = DIRECTED_RESTART[i];
            send_key(d);
        end

        run_phase(COUNT_W'(0), 300, IDLE_SENDER);
        run_phase(COUNT_W'(3), 600, IDLE_RECEIVER);
        // lower the count part way through a generation
        run_phase(COUNT_W'(1), 200, IDLE_BOTH);
        run_phase(COUNT_W'(2047), 300, IDLE_NONE);
        run_phase(MAX_PASSES, 150, IDLE_SENDER);
        run_phase(COUNT_W'(2), 100, IDLE_RECEIVER);

        in_valid <= 1'b0;
        set_idling(IDLE_NONE);
        waited = 0;
        while (sb.expected_writes.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.expected_writes.size() != 0) begin
            $display("%0d expected box writes never arrived", sb.expected_writes.size());
            sb.mismatches += sb.expected_writes.size();
        end
        $display("Covered %0d box writes, %0d taken from a stored arrangement, %0d restarts.",
                 sb.writes_checked, sb.stored_reads, sb.restarts);
        $display("%0d generations completed over pass counts 0 to 2047 and four idling patterns.",
                 sb.boxes_done);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
